/* rtl/ptqi_pkg.sv */
// Shared types and constants of the profile table interpolation unit.
package ptqi_pkg;

    localparam int MAG_W   = 32;           // magnitude of a value or coordinate difference
    localparam int PROD_W  = 2 * MAG_W;    // numerator / denominator products
    localparam int TERM_W  = MAG_W + PROD_W; // column value times numerator
    localparam int QUOT_W  = 61;           // quotient, capped at 2^60
    localparam int CAP_BIT = 60;
    localparam int MIN_NODES = 4;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_INTERP = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FEW      = 2'd1,
        ST_ZERO_DEN = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

endpackage

/* rtl/ptqi_if.sv */
// Valid/ready channel interfaces for requests and result beats.
interface ptqi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [7:0]         node_index;
    logic [3:0]         column;
    logic signed [31:0] write_value;
    logic signed [31:0] query_point;

    modport source (output valid, opcode, node_index, column, write_value, query_point,
                    input ready);
    modport sink   (input valid, opcode, node_index, column, write_value, query_point,
                    output ready);
endinterface

interface ptqi_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_column;
    logic signed [31:0] out_value;
    logic               last;
    logic [1:0]         status;

    modport source (output valid, out_column, out_value, last, status, input ready);
    modport sink   (input valid, out_column, out_value, last, status, output ready);
endinterface

/* rtl/ptqi_store.sv */
// Profile store: one write port, one read port, registered read data.
module ptqi_store #(
    parameter int DEPTH  = 3840,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/ptqi_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle.
module ptqi_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ptqi_pkg::MAG_W-1:0] a,
    input  logic [ptqi_pkg::PROD_W-1:0] b,
    output logic                       done,
    output logic [ptqi_pkg::TERM_W-1:0] prod
);
    import ptqi_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [TERM_W-1:0] p_reg;
    logic [PROD_W-1:0] b_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W:0]   upper;

    assign upper = {1'b0, p_reg[TERM_W-1:MAG_W]} + (p_reg[0] ? {1'b0, b_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= {{PROD_W{1'b0}}, a};
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            p_reg <= {upper, p_reg[MAG_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;
endmodule

/* rtl/ptqi_div.sv */
// Restoring divider, one quotient bit per cycle; quotient capped at 2^60.
module ptqi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ptqi_pkg::TERM_W-1:0] dividend,
    input  logic [ptqi_pkg::PROD_W-1:0] divisor,
    output logic                        done,
    output logic [ptqi_pkg::QUOT_W-1:0] quot
);
    import ptqi_pkg::*;

    localparam int CNT_W = $clog2(TERM_W + 1);

    logic [TERM_W-1:0] num_reg;
    logic [PROD_W-1:0] den_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W:0]   trial;
    logic [PROD_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, num_reg[TERM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TERM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[TERM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
            q_reg   <= {q_reg[QUOT_W-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[CAP_BIT];
        end
    end

    // once the running quotient reaches 2^60 the answer is the cap
    assign quot = (ovf_reg || q_reg[CAP_BIT]) ? (QUOT_W'(1) << CAP_BIT) : q_reg;
    assign done = done_reg;
endmodule

/* rtl/profile_table_quadratic_interp_unit.sv */
// Profile node table with three-point quadratic interpolation (top level).
//
// Requests come in on in_ch (valid/ready): write one column of a node, read all
// columns of a node, or interpolate every column at a query coordinate. Reads and
// interpolations each return NUM_COLUMNS result beats on out_ch in column order,
// last set on the final beat; writes and no-op requests return nothing.
// node_count_we/node_count_wdata set the number of nodes in use; write it only
// while the unit is idle.
// The unit works on one request at a time. A write goes straight into the table
// when accepted. A read emits each column beat through address, capture and emit
// steps. An interpolation runs a search and setup, then 6 products, then per
// column three terms (table read, shift-add multiply, restoring divide) and an
// emit step. Error runs emit one beat per cycle while the receiver is ready.
// The table lives in one synchronous memory; each search step is one read.
// Reset clears control state and node_count; table contents stay undefined
// until written. When the receiver stalls, the output register holds the beat
// and the sequencer waits; the final beat of a run frees the input side at once.
module profile_table_quadratic_interp_unit #(
    parameter int MAX_NODES   = 256,
    parameter int NUM_COLUMNS = 15,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ptqi_in_if.sink              in_ch,
    ptqi_out_if.source           out_ch,
    input  logic                 node_count_we,
    input  logic [8:0]           node_count_wdata
);
    import ptqi_pkg::*;

    localparam int NODES_USED = MAX_NODES < 256 ? MAX_NODES : 256;
    localparam int DEPTH      = NODES_USED * NUM_COLUMNS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COL_W      = $clog2(NUM_COLUMNS);
    localparam int SAT_W      = VALUE_WIDTH < 32 ? VALUE_WIDTH : 32;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef enum logic [1:0] {RUN_READ, RUN_INTERP, RUN_CONST} run_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD0, S_CK0, S_RDL, S_CKL, S_LOOP, S_LCK, S_NLO, S_NHI,
        S_XRD, S_XCAP, S_CHK, S_PROD, S_PWAIT, S_FRD, S_FCAP, S_FMUL, S_FDIV,
        S_RRD, S_RCAP, S_EMIT
    } state_t;

    function automatic logic signed [31:0] sat_val(input logic signed [63:0] v);
        logic signed [31:0] r;
        priority if (v > SAT_HI) r = SAT_HI[31:0];
        else if (v < SAT_LO) r = SAT_LO[31:0];
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag32(input logic signed [31:0] v);
        logic [31:0] neg;
        neg = ~v + 32'd1;
        return v[31] ? neg : v;
    endfunction

    function automatic logic [MAG_W-1:0] mag33(input logic signed [32:0] v);
        logic [32:0] neg;
        neg = ~v + 33'd1;
        return v[32] ? neg[31:0] : v[31:0];
    endfunction

    state_t             state_reg;
    run_t               run_reg;
    logic [8:0]         count_reg;
    logic [COL_W-1:0]   col_reg;
    logic [7:0]         node_reg;
    logic signed [31:0] qp_reg;
    logic [7:0]         lo_reg, hi_reg, mid_reg, idx0_reg;
    logic signed [31:0] xlo_reg;
    logic [1:0]         k_reg;
    logic [2:0]         p_reg;
    logic signed [31:0] xs_reg [3];
    logic [PROD_W-1:0]  dm_reg [3];
    logic [PROD_W-1:0]  nm_reg [3];
    logic [2:0]         sg_reg;
    logic               neg_reg;
    logic signed [63:0] sum_reg;
    logic signed [31:0] pend_value_reg;
    status_t            pend_status_reg;

    logic               out_valid_reg;
    logic [3:0]         out_column_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;
    logic [1:0]         out_status_reg;

    logic [8:0]         n_eff;
    logic               out_free;
    logic               in_fire;
    logic [5:0]         col_wide;
    logic               col_last;

    // store ports
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [31:0]        wr_data;
    logic [7:0]         rd_node;
    logic [COL_W-1:0]   rd_col;
    logic [ADDR_W-1:0]  rd_addr;
    logic signed [31:0] rd_data;

    // arithmetic units
    logic               mul_start, mul_done;
    logic [MAG_W-1:0]   mul_a;
    logic [PROD_W-1:0]  mul_b;
    logic [TERM_W-1:0]  mul_prod;
    logic               div_start, div_done;
    logic [QUOT_W-1:0]  div_quot;

    // per-node Lagrange factors
    logic [MAG_W-1:0]   da [3], db [3], na [3], nb [3];
    logic [2:0]         sg_calc;
    logic [1:0]         pi;

    logic [8:0]         mid_sum;
    logic [7:0]         near_pick;
    logic [7:0]         idx0_near;
    logic signed [63:0] sum_add;
    logic signed [31:0] f_val;

    assign n_eff    = (32'(count_reg) < MAX_NODES) ? count_reg : 9'(MAX_NODES);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign col_wide = 6'(col_reg);
    assign col_last = col_reg == COL_W'(NUM_COLUMNS - 1);
    assign in_ch.ready = state_reg == S_IDLE;

    // write path: out-of-range nodes and columns are dropped
    assign wr_en   = in_fire && (in_ch.opcode == OP_WRITE)
                     && ({1'b0, in_ch.node_index} < n_eff)
                     && (32'(in_ch.column) < NUM_COLUMNS);
    assign wr_addr = ADDR_W'(32'(in_ch.node_index) * NUM_COLUMNS
                     + 32'(COL_W'(in_ch.column)));
    assign wr_data = sat_val(64'(in_ch.write_value));

    // read address follows the sequencer state
    always_comb
    begin
        rd_node = 8'd0;
        rd_col  = '0;
        unique case (state_reg)
            S_RDL:  rd_node = 8'(n_eff - 9'd1);
            S_LOOP: rd_node = ({1'b0, hi_reg} > {1'b0, lo_reg} + 9'd1) ? mid_sum[8:1] : lo_reg;
            S_NLO:  rd_node = hi_reg;
            S_XRD:  rd_node = idx0_reg + 8'(k_reg);
            S_FRD:
            begin
                rd_node = idx0_reg + 8'(k_reg);
                rd_col  = col_reg;
            end
            S_RRD:
            begin
                rd_node = node_reg;
                rd_col  = col_reg;
            end
            default: rd_node = 8'd0;
        endcase
    end
    assign rd_addr = ADDR_W'(32'(rd_node) * NUM_COLUMNS + 32'(rd_col));
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    ptqi_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // differences for the three nodes; node i pairs with the next two cyclically
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [32:0] d1, d2, n1, n2;
            d1 = 33'(xs_reg[i]) - 33'(xs_reg[(i + 1) % 3]);
            d2 = 33'(xs_reg[i]) - 33'(xs_reg[(i + 2) % 3]);
            n1 = 33'(qp_reg) - 33'(xs_reg[(i + 1) % 3]);
            n2 = 33'(qp_reg) - 33'(xs_reg[(i + 2) % 3]);
            da[i] = mag33(d1);
            db[i] = mag33(d2);
            na[i] = mag33(n1);
            nb[i] = mag33(n2);
            sg_calc[i] = (d1[32] ^ d2[32]) ^ (n1[32] ^ n2[32]);
        end
    end

    assign pi        = p_reg[2:1];
    assign f_val     = rd_data;
    assign mul_start = (state_reg == S_PROD) || (state_reg == S_FCAP);
    assign mul_a     = (state_reg == S_FCAP) ? mag32(f_val) : (p_reg[0] ? na[pi] : da[pi]);
    assign mul_b     = (state_reg == S_FCAP) ? nm_reg[k_reg]
                       : PROD_W'(p_reg[0] ? nb[pi] : db[pi]);
    assign div_start = (state_reg == S_FMUL) && mul_done;

    ptqi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ptqi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (dm_reg[k_reg]),
        .done     (div_done),
        .quot     (div_quot)
    );

    // nearest node after the search, then shifted inward at the table ends
    always_comb
    begin
        logic signed [32:0] dlo, dhi;
        dlo = 33'(qp_reg) - 33'(xlo_reg);
        dhi = 33'(qp_reg) - 33'(rd_data);
        near_pick = (mag33(dlo) < mag33(dhi)) ? lo_reg : hi_reg;
        priority if (near_pick == 8'd0) idx0_near = 8'd0;
        else if ({1'b0, near_pick} == n_eff - 9'd1) idx0_near = 8'(n_eff - 9'd3);
        else idx0_near = near_pick - 8'd1;
    end

    assign sum_add = neg_reg ? sum_reg - 64'(div_quot) : sum_reg + 64'(div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= RUN_CONST;
            count_reg     <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (node_count_we)
            begin
                count_reg <= node_count_wdata;
            end
            // a new beat loads the output register, an accepted one empties it
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        node_reg        <= in_ch.node_index;
                        qp_reg          <= in_ch.query_point;
                        col_reg         <= '0;
                        pend_value_reg  <= '0;
                        unique case (in_ch.opcode)
                            OP_READ:
                            begin
                                if ({1'b0, in_ch.node_index} >= n_eff)
                                begin
                                    run_reg         <= RUN_CONST;
                                    pend_status_reg <= ST_RANGE;
                                    state_reg       <= S_EMIT;
                                end
                                else
                                begin
                                    run_reg         <= RUN_READ;
                                    pend_status_reg <= ST_OK;
                                    state_reg       <= S_RRD;
                                end
                            end
                            OP_INTERP:
                            begin
                                if (n_eff < 9'(MIN_NODES))
                                begin
                                    run_reg         <= RUN_CONST;
                                    pend_status_reg <= ST_FEW;
                                    state_reg       <= S_EMIT;
                                end
                                else
                                begin
                                    run_reg         <= RUN_INTERP;
                                    pend_status_reg <= ST_OK;
                                    state_reg       <= S_RD0;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_RD0: state_reg <= S_CK0;
                S_CK0:
                begin
                    if (qp_reg <= rd_data)
                    begin
                        idx0_reg  <= 8'd0;
                        k_reg     <= 2'd0;
                        state_reg <= S_XRD;
                    end
                    else
                    begin
                        state_reg <= S_RDL;
                    end
                end
                S_RDL: state_reg <= S_CKL;
                S_CKL:
                begin
                    if (qp_reg >= rd_data)
                    begin
                        idx0_reg  <= 8'(n_eff - 9'd3);
                        k_reg     <= 2'd0;
                        state_reg <= S_XRD;
                    end
                    else
                    begin
                        lo_reg    <= 8'd0;
                        hi_reg    <= 8'(n_eff - 9'd1);
                        state_reg <= S_LOOP;
                    end
                end
                S_LOOP:
                begin
                    if ({1'b0, hi_reg} > {1'b0, lo_reg} + 9'd1)
                    begin
                        mid_reg   <= mid_sum[8:1];
                        state_reg <= S_LCK;
                    end
                    else
                    begin
                        state_reg <= S_NLO;
                    end
                end
                S_LCK:
                begin
                    if (qp_reg >= rd_data)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_LOOP;
                end
                S_NLO:
                begin
                    xlo_reg   <= rd_data;
                    state_reg <= S_NHI;
                end
                S_NHI:
                begin
                    idx0_reg  <= idx0_near;
                    k_reg     <= 2'd0;
                    state_reg <= S_XRD;
                end
                S_XRD: state_reg <= S_XCAP;
                S_XCAP:
                begin
                    xs_reg[k_reg] <= rd_data;
                    if (k_reg == 2'd2)
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_XRD;
                    end
                end
                S_CHK:
                begin
                    // two coinciding coordinates make a denominator vanish
                    if (xs_reg[0] == xs_reg[1] || xs_reg[1] == xs_reg[2]
                        || xs_reg[0] == xs_reg[2])
                    begin
                        run_reg         <= RUN_CONST;
                        pend_status_reg <= ST_ZERO_DEN;
                        state_reg       <= S_EMIT;
                    end
                    else
                    begin
                        sg_reg    <= sg_calc;
                        p_reg     <= 3'd0;
                        state_reg <= S_PROD;
                    end
                end
                S_PROD: state_reg <= S_PWAIT;
                S_PWAIT:
                begin
                    if (mul_done)
                    begin
                        if (p_reg[0])
                        begin
                            nm_reg[pi] <= mul_prod[PROD_W-1:0];
                        end
                        else
                        begin
                            dm_reg[pi] <= mul_prod[PROD_W-1:0];
                        end
                        if (p_reg == 3'd5)
                        begin
                            col_reg   <= '0;
                            k_reg     <= 2'd0;
                            sum_reg   <= '0;
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            p_reg     <= p_reg + 3'd1;
                            state_reg <= S_PROD;
                        end
                    end
                end
                S_FRD: state_reg <= S_FCAP;
                S_FCAP:
                begin
                    neg_reg   <= sg_reg[k_reg] ^ f_val[31];
                    state_reg <= S_FMUL;
                end
                S_FMUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_FDIV;
                    end
                end
                S_FDIV:
                begin
                    if (div_done)
                    begin
                        sum_reg <= sum_add;
                        if (k_reg == 2'd2)
                        begin
                            pend_value_reg <= sat_val(sum_add);
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_FRD;
                        end
                    end
                end
                S_RRD: state_reg <= S_RCAP;
                S_RCAP:
                begin
                    pend_value_reg <= rd_data;
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_column_reg <= col_wide[3:0];
                        out_value_reg  <= pend_value_reg;
                        out_last_reg   <= col_last;
                        out_status_reg <= pend_status_reg;
                        if (col_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                            unique case (run_reg)
                                RUN_INTERP:
                                begin
                                    k_reg     <= 2'd0;
                                    sum_reg   <= '0;
                                    state_reg <= S_FRD;
                                end
                                RUN_READ: state_reg <= S_RRD;
                                default:  state_reg <= S_EMIT;
                            endcase
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_column = out_column_reg;
    assign out_ch.out_value  = out_value_reg;
    assign out_ch.last       = out_last_reg;
    assign out_ch.status     = out_status_reg;

`ifndef ASSERT_OFF
    a_last_on_final_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last |-> out_ch.out_column == 4'(NUM_COLUMNS - 1))
        else $error("last beat not on final column");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.out_value == 32'sd0)
        else $error("error beat carries nonzero value");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_IDLE)
        else $error("table write outside idle");

    a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> $past(mul_start, 1) == 1'b0 && state_reg == S_FMUL)
        else $error("divide started without finished product");
`endif

endmodule

/* tb/tb_profile_table_quadratic_interp_unit.sv */
// Self-checking testbench for the profile table interpolation unit.
`timescale 1ns / 100ps

module tb_profile_table_quadratic_interp_unit;
    import ptqi_pkg::*;

    localparam int NODES = 256;
    localparam int COLS  = 15;

    typedef struct {
        opcode_t            op;
        logic [7:0]         node;
        logic [3:0]         col;
        logic signed [31:0] wval;
        logic signed [31:0] qpt;
    } request_t;

    typedef struct {
        logic [3:0]         col;
        logic signed [31:0] val;
        logic               last;
        status_t            st;
    } beat_t;

    logic clk;
    logic rst_n;
    logic       node_count_we;
    logic [8:0] node_count_wdata;

    ptqi_in_if  in_ch ();
    ptqi_out_if out_ch ();

    profile_table_quadratic_interp_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata)
    );

    // Shadow copy of the table and node count, kept in step with accepted beats.
    logic signed [31:0] shadow_table [0:NODES*COLS-1];
    logic [8:0]         shadow_count;

    request_t requests[$];
    beat_t    expected_beats[$];
    int       error_count;
    bit       driver_busy;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int active_nodes();
        return (shadow_count > NODES) ? NODES : int'(shadow_count);
    endfunction

    function automatic longint table_val(int node, int col);
        return longint'(shadow_table[node*COLS + col]);
    endfunction

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Nearest node by binary search on column 0; ties go to the upper node.
    function automatic int nearest_node(longint q, int n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        if (q <= table_val(0, 0))
            return 0;
        if (q >= table_val(n - 1, 0))
            return n - 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (q >= table_val(mid, 0))
                lo = mid;
            else
                hi = mid;
        end
        if (mag64(q - table_val(lo, 0)) < mag64(q - table_val(hi, 0)))
            return lo;
        return hi;
    endfunction

    // trunc(f * num / den), magnitude capped at 2^60.
    function automatic longint weighted_term(longint f, logic [63:0] num,
                                             logic [63:0] den, bit sgn);
        logic [127:0] prod;
        logic [127:0] quot;
        bit           neg;
        neg  = sgn ^ (f < 0);
        prod = {64'd0, mag64(f)} * {64'd0, num};
        quot = prod / {64'd0, den};
        if (quot > (128'd1 << CAP_BIT))
            quot = 128'd1 << CAP_BIT;
        return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > longint'(32'sh7fff_ffff))
            return 32'sh7fff_ffff;
        if (v < -longint'(64'h8000_0000))
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic void push_beat(int c, logic signed [31:0] v, status_t st);
        beat_t b;
        b.col  = 4'(c);
        b.val  = v;
        b.last = (c == COLS - 1);
        b.st   = st;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    function automatic void push_constant_run(status_t st);
        for (int c = 0; c < COLS; c++)
            push_beat(c, 32'sd0, st);
    endfunction

    function automatic void predict_interp(longint q);
        int          n;
        int          near;
        int          idx [3];
        logic [63:0] num [3];
        logic [63:0] den [3];
        bit          sg  [3];
        longint      xi, xb, xc, d1, d2, n1, n2, sum;
        n = active_nodes();
        if (n < MIN_NODES)
        begin
            push_constant_run(ST_FEW);
            return;
        end
        near = nearest_node(q, n);
        if (near == 0)
            near = 1;
        else if (near == n - 1)
            near = n - 2;
        for (int i = 0; i < 3; i++)
            idx[i] = near - 1 + i;
        for (int i = 0; i < 3; i++)
        begin
            xi = table_val(idx[i], 0);
            xb = table_val(idx[(i + 1) % 3], 0);
            xc = table_val(idx[(i + 2) % 3], 0);
            d1 = xi - xb;
            d2 = xi - xc;
            n1 = q - xb;
            n2 = q - xc;
            if (d1 == 0 || d2 == 0)
            begin
                push_constant_run(ST_ZERO_DEN);
                return;
            end
            den[i] = mag64(d1) * mag64(d2);
            num[i] = mag64(n1) * mag64(n2);
            sg[i]  = ((d1 < 0) ^ (d2 < 0)) ^ ((n1 < 0) ^ (n2 < 0));
        end
        for (int c = 0; c < COLS; c++)
        begin
            sum = 0;
            for (int i = 0; i < 3; i++)
                sum += weighted_term(table_val(idx[i], c), num[i], den[i], sg[i]);
            push_beat(c, sat32(sum), ST_OK);
        end
    endfunction

    function automatic void predict_request(request_t r);
        case (r.op)
            OP_WRITE:
                if (int'(r.node) < active_nodes() && r.col < COLS)
                    shadow_table[int'(r.node)*COLS + int'(r.col)] = r.wval;
            OP_READ:
                if (int'(r.node) >= active_nodes())
                    push_constant_run(ST_RANGE);
                else
                    for (int c = 0; c < COLS; c++)
                        push_beat(c, shadow_table[int'(r.node)*COLS + c], ST_OK);
            OP_INTERP:
                predict_interp(longint'(r.qpt));
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    request_t cur_req;
    int       burst_left;
    int       gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            driver_busy = 1'b0;
            burst_left  = 4;
            gap_left    = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_request(cur_req);   // expectations first, then release busy
                driver_busy = 1'b0;
            end
            if (!driver_busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (requests.size() > 0)
                begin
                    cur_req = requests.pop_front();
                    driver_busy = 1'b1;
                    in_ch.valid       <= 1'b1;
                    in_ch.opcode      <= cur_req.op;
                    in_ch.node_index  <= cur_req.node;
                    in_ch.column      <= cur_req.col;
                    in_ch.write_value <= cur_req.wval;
                    in_ch.query_point <= cur_req.qpt;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        // a third of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall pattern switches between modes every so often
    // ------------------------------------------------------------------
    int stall_mode;
    int mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: col %0d value %0d",
                           out_ch.out_column, out_ch.out_value);
                    error_count++;
                end
                else
                begin
                    beat_t e;
                    e = expected_beats.pop_front();
                    if (out_ch.out_column !== e.col)
                    begin
                        $error("out_column: expected %0d, got %0d", e.col, out_ch.out_column);
                        error_count++;
                    end
                    if (out_ch.out_value !== e.val)
                    begin
                        $error("out_value: expected %0d, got %0d", e.val, out_ch.out_value);
                        error_count++;
                    end
                    if (out_ch.last !== e.last)
                    begin
                        $error("last: expected %0b, got %0b", e.last, out_ch.last);
                        error_count++;
                    end
                    if (out_ch.status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, out_ch.status);
                        error_count++;
                    end
                end
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_request(opcode_t op, int node, int col, logic [31:0] wv,
                               logic [31:0] qp);
        request_t r;
        r.op   = op;
        r.node = 8'(node);
        r.col  = 4'(col);
        r.wval = wv;
        r.qpt  = qp;
        requests.insert(requests.size(), r);
    endtask

    // Let every queued beat go out and every result come back; writes give no
    // result, so the task idles on after the last one.
    task automatic drain();
        while (requests.size() > 0 || driver_busy || expected_beats.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_node_count(int v);
        drain();
        @(posedge clk);
        node_count_we    <= 1'b1;
        node_count_wdata <= 9'(v);
        @(posedge clk);
        node_count_we    <= 1'b0;
        shadow_count = 9'(v);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    // Write column 0 of nodes 0..n-1 (ascending unless scrambled) and every
    // other column of nodes first..n-1; lower nodes keep their earlier columns.
    task automatic fill_table(int n, int first, bit scrambled);
        longint step;
        longint base;
        step = 64'h7fff_0000 / (n + 1);
        if ($urandom_range(0, 1) == 0 && step > 64'h40000)
            step = $urandom_range(32'h100, 32'h40000);
        base = -(step * n) / 2;
        for (int i = 0; i < n; i++)
        begin
            if (scrambled)
                add_request(OP_WRITE, i, 0, 32'($urandom_range(0, 7)) << 20, 0);
            else
                add_request(OP_WRITE, i, 0,
                            32'(base + step * i + $urandom_range(0, 32'(step / 2))), 0);
            if (i >= first)
                for (int c = 1; c < COLS; c++)
                    add_request(OP_WRITE, i, c, rand_value(), 0);
        end
    endtask

    // Query point near the table: close to a node, between two, or anywhere.
    function automatic logic [31:0] rand_query(int n);
        longint a;
        int     k;
        k = $urandom_range(0, n - 1);
        a = table_val(k, 0);
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'(a);
            2:       return 32'((a + table_val((k + 1) % n, 0)) / 2);
            default: return 32'(a) + 32'($urandom_range(0, 65536)) - 32'd32768;
        endcase
    endfunction

    task automatic random_phase(int n, int count);
        int r;
        int col;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                col = $urandom_range(0, 15);
                if (col == 0 && $urandom_range(0, 3) != 0)
                    col = $urandom_range(1, 14);
                add_request(OP_WRITE,
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, n - 1),
                            col, rand_value(), $urandom);
            end
            else if (r < 72)
                add_request(OP_READ,
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, n - 1),
                            $urandom_range(0, 15), $urandom, $urandom);
            else if (r < 92)
                add_request(OP_INTERP, $urandom_range(0, 255), $urandom_range(0, 15),
                            $urandom, rand_query(n));
            else
                add_request(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 15),
                            $urandom, $urandom);
        end
    endtask

    initial
    begin
        longint x1;
        longint x2;
        error_count      = 0;
        shadow_count     = 9'd0;
        rst_n            = 1'b0;
        node_count_we    = 1'b0;
        node_count_wdata = 9'd0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_NOP;
        in_ch.node_index  = 8'd0;
        in_ch.column      = 4'd0;
        in_ch.write_value = 32'sd0;
        in_ch.query_point = 32'sd0;
        out_ch.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: too few nodes, read out of range, write ignored, no-op.
        add_request(OP_INTERP, 0, 0, 0, 0);
        add_request(OP_READ, 0, 0, 0, 0);
        add_request(OP_WRITE, 0, 0, 32'h1234, 0);
        add_request(OP_NOP, 255, 15, 32'hffff_ffff, 32'hffff_ffff);

        // Three nodes is still too few to interpolate.
        set_node_count(3);
        fill_table(3, 0, 0);
        add_request(OP_INTERP, 0, 0, 0, 32'h0001_0000);
        add_request(OP_READ, 2, 0, 0, 0);
        add_request(OP_READ, 3, 0, 0, 0);

        // Four nodes: clamping at both ends, exact hit, tie, saturating columns.
        set_node_count(4);
        fill_table(4, 3, 0);
        for (int i = 0; i < 4; i++)
        begin
            add_request(OP_WRITE, i, 1, 32'h7fff_ffff, 0);
            add_request(OP_WRITE, i, 2, (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff, 0);
        end
        drain();
        x1 = table_val(1, 0);
        x2 = table_val(2, 0);
        add_request(OP_INTERP, 0, 0, 0, 32'h8000_0000);
        add_request(OP_INTERP, 0, 0, 0, 32'h7fff_ffff);
        add_request(OP_INTERP, 0, 0, 0, 32'(x1));
        add_request(OP_INTERP, 0, 0, 0, 32'((x1 + x2) / 2));
        add_request(OP_WRITE, 1, 15, 32'h5555, 0);     // column past the end
        add_request(OP_WRITE, 4, 3, 32'h5555, 0);      // node past the count
        add_request(OP_READ, 1, 0, 0, 0);
        add_request(OP_READ, 255, 0, 0, 0);
        // coinciding coordinates among the three chosen nodes
        add_request(OP_WRITE, 1, 0, 32'(table_val(0, 0)), 0);
        add_request(OP_INTERP, 0, 0, 0, 32'h8000_0000);

        // Count register above the node limit: the top node becomes writable.
        set_node_count(511);
        for (int c = 0; c < COLS; c++)
            add_request(OP_WRITE, 255, c, rand_value(), 0);
        add_request(OP_READ, 255, 0, 0, 0);
        add_request(OP_READ, 3, 0, 0, 0);

        set_node_count(256);
        add_request(OP_READ, 255, 0, 0, 0);

        for (int p = 0; p < 3; p++)
        begin
            int n;
            n = $urandom_range(4, 7);
            set_node_count(n);
            fill_table(n, 4, 0);
            random_phase(n, 30);
        end

        // Unordered coordinates, many repeats among them.
        set_node_count(6);
        fill_table(6, 4, 1);
        random_phase(6, 30);

        drain();
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("** profile_table_quadratic_interp_unit: PASSED **");
        else
            $display("** profile_table_quadratic_interp_unit: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #60_000_000;
        $display("** profile_table_quadratic_interp_unit: FAILED **");
        $finish;
    end

endmodule
